// ===== rtl/core/brde_pkg.sv =====
// shared types, codes and helpers of the byte run delta encoder
`default_nettype none

package brde_pkg;

   localparam int OFFSET_WIDTH = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_RANGE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_ID_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_OLD_VERSION = 2'd2;

   localparam logic [1:0] CSR_BASE_SYSTEM_ID   = 2'd0;
   localparam logic [1:0] CSR_TARGET_SYSTEM_ID = 2'd1;
   localparam logic [1:0] CSR_BASE_VERSION     = 2'd2;
   localparam logic [1:0] CSR_TARGET_VERSION   = 2'd3;

   // record slots inside one queue entry, emitted lowest first
   localparam int REC_RANGE_FIRST  = 0;
   localparam int REC_DATA         = 1;
   localparam int REC_RANGE_SECOND = 2;
   localparam int REC_DONE         = 3;
   localparam int REC_SLOTS        = 4;

   typedef struct packed {
      logic [7:0] base_byte;
      logic [7:0] target_byte;
      logic       has_base;
      logic       has_target;
      logic       final_position;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  data_byte;
      logic [31:0] range_offset;
      logic [31:0] range_length;
      logic [1:0]  status;
      logic [31:0] ranges_total;
      logic [31:0] data_total;
      logic [31:0] bytes_saved;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [REC_SLOTS-1:0]    recs;
      logic [OFFSET_WIDTH-1:0] first_offset;
      logic [31:0]             first_length;
      logic [7:0]              data_byte;
      logic [OFFSET_WIDTH-1:0] second_offset;
      logic [31:0]             second_length;
      logic [1:0]              status;
      logic [31:0]             ranges_total;
      logic [31:0]             data_total;
      logic [31:0]             base_length;
      logic [31:0]             target_length;
   } entry_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brde_front.sv =====
// front end: registers, byte classification, run tracking, entry build
`default_nettype none

module brde_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [31:0]         csr_data,
   input  wire logic                accept,
   input  wire brde_pkg::req_type   item,
   output logic                     entry_push,
   output brde_pkg::entry_type      entry
);

   localparam int OW = brde_pkg::OFFSET_WIDTH;

   logic [31:0]   base_sys_ff, target_sys_ff, base_ver_ff, target_ver_ff;
   logic [OW-1:0] position_ff, position_in;
   logic          run_open_ff, run_open_in;
   logic          run_tail_ff, run_tail_in;
   logic [OW-1:0] run_start_ff, run_start_in;
   logic [31:0]   run_length_ff, run_length_in;
   logic [31:0]   range_count_ff, range_count_in;
   logic [31:0]   data_count_ff, data_count_in;
   logic [31:0]   base_length_ff, base_length_in;
   logic [31:0]   target_length_ff, target_length_in;

   logic [1:0]  status;
   logic        ok, diff, tail, any, close_first, close_second, keep_run;
   logic [31:0] count_after_first, count_after_second;

   always_comb begin
      if (base_sys_ff != target_sys_ff) begin
         status = brde_pkg::STATUS_ID_MISMATCH;
      end else if (base_ver_ff >= target_ver_ff) begin
         status = brde_pkg::STATUS_OLD_VERSION;
      end else begin
         status = brde_pkg::STATUS_OK;
      end
      ok   = (status == brde_pkg::STATUS_OK);
      diff = item.has_target & item.has_base & (item.base_byte != item.target_byte);
      tail = item.has_target & ~item.has_base;
      any  = diff | tail;

      // a run closes on a clean byte or when it would change kind
      close_first = ok & run_open_ff & (~any | (tail != run_tail_ff));
      keep_run    = run_open_ff & ~close_first;
      count_after_first = close_first ? brde_pkg::sat_inc32(range_count_ff) : range_count_ff;

      position_in      = position_ff;
      run_open_in      = run_open_ff;
      run_tail_in      = run_tail_ff;
      run_start_in     = run_start_ff;
      run_length_in    = run_length_ff;
      data_count_in    = data_count_ff;
      base_length_in   = base_length_ff;
      target_length_in = target_length_ff;

      if (ok) begin
         position_in = (position_ff == {OW{1'b1}}) ? position_ff : position_ff + OW'(1);
         if (item.has_base) begin
            base_length_in = brde_pkg::sat_inc32(base_length_ff);
         end
         if (item.has_target) begin
            target_length_in = brde_pkg::sat_inc32(target_length_ff);
         end
         if (any) begin
            run_open_in   = 1'b1;
            run_tail_in   = keep_run ? run_tail_ff : tail;
            run_start_in  = keep_run ? run_start_ff : position_ff;
            run_length_in = keep_run ? brde_pkg::sat_inc32(run_length_ff) : 32'd1;
            data_count_in = brde_pkg::sat_inc32(data_count_ff);
         end else if (close_first) begin
            run_open_in   = 1'b0;
            run_tail_in   = 1'b0;
            run_start_in  = '0;
            run_length_in = '0;
         end
      end

      close_second       = ok & item.final_position & run_open_in;
      count_after_second = close_second ? brde_pkg::sat_inc32(count_after_first)
                                        : count_after_first;
      range_count_in     = count_after_first;

      entry.recs[brde_pkg::REC_RANGE_FIRST]  = close_first;
      entry.recs[brde_pkg::REC_DATA]         = ok & any;
      entry.recs[brde_pkg::REC_RANGE_SECOND] = close_second;
      entry.recs[brde_pkg::REC_DONE]         = item.final_position;
      entry.first_offset  = run_start_ff;
      entry.first_length  = run_length_ff;
      entry.data_byte     = item.target_byte;
      entry.second_offset = run_start_in;
      entry.second_length = run_length_in;
      entry.status        = status;
      entry.ranges_total  = ok ? count_after_second : '0;
      entry.data_total    = ok ? data_count_in : '0;
      entry.base_length   = ok ? base_length_in : '0;
      entry.target_length = ok ? target_length_in : '0;

      entry_push = accept & (entry.recs != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_sys_ff      <= '0;
         target_sys_ff    <= '0;
         base_ver_ff      <= '0;
         target_ver_ff    <= '0;
         position_ff      <= '0;
         run_open_ff      <= 1'b0;
         run_tail_ff      <= 1'b0;
         run_start_ff     <= '0;
         run_length_ff    <= '0;
         range_count_ff   <= '0;
         data_count_ff    <= '0;
         base_length_ff   <= '0;
         target_length_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               brde_pkg::CSR_BASE_SYSTEM_ID:   base_sys_ff   <= csr_data;
               brde_pkg::CSR_TARGET_SYSTEM_ID: target_sys_ff <= csr_data;
               brde_pkg::CSR_BASE_VERSION:     base_ver_ff   <= csr_data;
               brde_pkg::CSR_TARGET_VERSION:   target_ver_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            if (item.final_position) begin
               // job ends: back to the reset picture
               position_ff      <= '0;
               run_open_ff      <= 1'b0;
               run_tail_ff      <= 1'b0;
               run_start_ff     <= '0;
               run_length_ff    <= '0;
               range_count_ff   <= '0;
               data_count_ff    <= '0;
               base_length_ff   <= '0;
               target_length_ff <= '0;
            end else begin
               position_ff      <= position_in;
               run_open_ff      <= run_open_in;
               run_tail_ff      <= run_tail_in;
               run_start_ff     <= run_start_in;
               run_length_ff    <= run_length_in;
               range_count_ff   <= range_count_in;
               data_count_ff    <= data_count_in;
               base_length_ff   <= base_length_in;
               target_length_ff <= target_length_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/brde_queue.sv =====
// short entry queue between front and back end
`default_nettype none

module brde_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire brde_pkg::entry_type push_entry,
   input  wire logic                pop,
   output brde_pkg::entry_type      head,
   output logic                     empty,
   output logic                     full
);

   localparam int PW = brde_pkg::QPTR_WIDTH;
   localparam int CW = $clog2(brde_pkg::QUEUE_DEPTH + 1);

   brde_pkg::entry_type slots_ff [brde_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(brde_pkg::QUEUE_DEPTH));
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/brde_back.sv =====
// back end: unpacks queue entries into result beats, output register
`default_nettype none

module brde_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire brde_pkg::entry_type head,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output brde_pkg::rsp_type        rsp_data,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop
);

   localparam int NR = brde_pkg::REC_SLOTS;

   brde_pkg::entry_type cur_ff, src;
   logic [NR-1:0]       mask_ff, mask_in, src_mask, sel;
   brde_pkg::rsp_type   rsp_ff, rsp_in;
   logic                valid_ff, use_cur, load;

   always_comb begin
      use_cur  = (mask_ff != '0);
      src      = use_cur ? cur_ff : head;
      src_mask = use_cur ? mask_ff : (q_empty ? '0 : head.recs);
      sel      = src_mask & (~src_mask + NR'(1));
      mask_in  = src_mask & ~sel;
      load     = (src_mask != '0) & (~valid_ff | rsp_pop);
      q_pop    = load & ~use_cur;

      rsp_in = '0;
      if (sel[brde_pkg::REC_RANGE_FIRST]) begin
         rsp_in.record_kind  = brde_pkg::KIND_RANGE;
         rsp_in.range_offset = 32'(src.first_offset);
         rsp_in.range_length = src.first_length;
      end else if (sel[brde_pkg::REC_DATA]) begin
         rsp_in.record_kind = brde_pkg::KIND_DATA;
         rsp_in.data_byte   = src.data_byte;
      end else if (sel[brde_pkg::REC_RANGE_SECOND]) begin
         rsp_in.record_kind  = brde_pkg::KIND_RANGE;
         rsp_in.range_offset = 32'(src.second_offset);
         rsp_in.range_length = src.second_length;
      end else begin
         rsp_in.record_kind  = brde_pkg::KIND_DONE;
         rsp_in.status       = src.status;
         rsp_in.ranges_total = src.ranges_total;
         rsp_in.data_total   = src.data_total;
         rsp_in.last_of_run  = 1'b1;
         // saving only counts when both snapshots are the same size
         if ((src.base_length == src.target_length) &&
             (src.target_length > src.data_total)) begin
            rsp_in.bytes_saved = src.target_length - src.data_total;
         end
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_empty = ~valid_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
      if (q_pop) begin
         cur_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            mask_ff  <= mask_in;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/byte_run_delta_encoder_unit.sv =====
// top level of the byte run delta encoder
// an accepted beat passes the entry queue and then the output register before its first result shows
// throughput: one position per cycle while each position gives at most one record and
//   results are popped; a position that gives several records holds the back end until all are out
// a four-entry queue parts the classifying front end from the record back end
// reset (synchronous, active high) clears job state, registers and queue at once
`default_nettype none

module byte_run_delta_encoder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   input  wire logic              req_push,
   input  wire brde_pkg::req_type req_data,
   output logic                   req_full,
   output brde_pkg::rsp_type      rsp_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop
);

   brde_pkg::entry_type push_entry, head;
   logic                accept, entry_push, q_pop, q_empty, q_full;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   brde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .item       (req_data),
      .entry_push (entry_push),
      .entry      (push_entry)
   );

   brde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   brde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

// ===== rtl/core/brde_checker.sv =====
// port-level checks on the encoder, bound to the top level
`default_nettype none

module brde_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_full,
   input  wire brde_pkg::rsp_type rsp_data,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side full after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("waiting result beat changed");

   a_last_on_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_of_run == (rsp_data.record_kind == brde_pkg::KIND_DONE)))
      else $error("last_of_run does not match done record");

   a_totals_on_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.record_kind != brde_pkg::KIND_DONE) |->
         (rsp_data.status == brde_pkg::STATUS_OK && rsp_data.ranges_total == '0 &&
          rsp_data.bytes_saved == '0))
      else $error("done fields set on a non-done record");

endmodule

bind byte_run_delta_encoder_unit brde_checker u_brde_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop)
);

`default_nettype wire
